// ===== sv/http_chunked_decoder_macros.svh =====
`ifndef HTTP_CHUNKED_DECODER_MACROS_SVH
`define HTTP_CHUNKED_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcd assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define HCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcd assertion failed");

`endif

// ===== sv/hcd_pkg.sv =====
package hcd_pkg;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [3:0] LINE_LEN_MAX = 4'd15;
  localparam logic [1:0] TRAILER_LEN  = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
    logic       is_sp;
    logic       is_zero;
  } hcd_item_t;

  function automatic hcd_item_t hcd_classify(input logic [7:0] c);
    hcd_item_t it;
    it.data    = c;
    it.hex_ok  = 1'b1;
    it.hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      it.hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      it.hex_val = c[3:0] + 4'd9;
    end else begin
      it.hex_ok = 1'b0;
    end
    it.is_cr   = (c == CHAR_CR);
    it.is_lf   = (c == CHAR_LF);
    it.is_sp   = (c == CHAR_SPACE);
    it.is_zero = (c == CHAR_ZERO);
    return it;
  endfunction

endpackage

// ===== sv/http_chunked_decoder.sv =====
// a payload byte passes the front register, a queue slot and the output register before it reaches out_*
// throughput: one byte per cycle while out_stall does not hold the back parser
// a four-entry queue between the byte classifier and the parser absorbs output stalls
// reset: synchronous active-low rst_n; parser restarts at a size line, max_line_len = 6
module http_chunked_decoder
  import hcd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_max_line_len,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic [1:0] out_kind
);

  logic      push_valid;
  hcd_item_t push_item;
  logic      push_full;
  logic      pop_valid;
  hcd_item_t pop_item;
  logic      pop_take;

  hcd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .push_valid   (push_valid),
    .push_item    (push_item),
    .push_full    (push_full)
  );

  hcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_full  (push_full),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_take   (pop_take)
  );

  hcd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_line_len (cfg_max_line_len),
    .pop_valid        (pop_valid),
    .pop_item         (pop_item),
    .pop_take         (pop_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_out_byte     (out_out_byte),
    .out_kind         (out_kind)
  );

endmodule

// ===== sv/hcd_front.sv =====
module hcd_front
  import hcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       push_valid,
  output hcd_item_t  push_item,
  input  logic       push_full
);

  logic      valid_r;
  logic      valid_nxt;
  hcd_item_t item_r;

  assign in_stall   = valid_r && push_full;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= hcd_classify(in_data_byte);
    end
  end

endmodule

// ===== sv/hcd_queue.sv =====
module hcd_queue
  import hcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  hcd_item_t push_item,
  output logic      push_full,
  output logic      pop_valid,
  output hcd_item_t pop_item,
  input  logic      pop_take
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  hcd_item_t       slots_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW-1:0]   rd_ptr_nxt;
  logic [PW:0]     count_r;
  logic [PW:0]     count_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_full = (count_r == PW'(0) + (PW+1)'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = slots_r[rd_ptr_r];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop_take && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/hcd_back.sv =====
module hcd_back
  import hcd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_max_line_len,
  input  logic       pop_valid,
  input  hcd_item_t  pop_item,
  output logic       pop_take,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic [1:0] out_kind
);

`include "http_chunked_decoder_macros.svh"

  localparam logic [2:0] PH_LINE    = 3'd0;
  localparam logic [2:0] PH_LINE_CR = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_TRAILER = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;
  localparam logic [2:0] PH_STOPPED = 3'd5;

  logic [3:0]            max_len_r;
  logic [2:0]            phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] chunk_r, chunk_nxt;
  logic [3:0]            len_r, len_nxt;
  logic                  first_r, first_nxt;
  logic                  stopped_r, stopped_nxt;
  logic                  seen_r, seen_nxt;
  logic [1:0]            trailer_r, trailer_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_byte_r, out_byte_nxt;
  logic [1:0]            out_kind_r, out_kind_nxt;

  logic                  ready;
  logic                  take;
  logic                  out_load;
  logic [3:0]            len_inc;
  logic                  tx_first;
  logic                  tx_stopped;
  logic                  tx_seen;
  logic [COUNT_BITS-1:0] tx_chunk;
  logic [COUNT_BITS-1:0] chunk_dec;
  logic [1:0]            trailer_dec;

  assign cfg_ready    = 1'b1;
  assign ready        = !out_valid_r || !out_stall;
  assign take         = pop_valid && ready;
  assign pop_take     = ready;
  assign out_valid    = out_valid_r;
  assign out_out_byte = out_byte_r;
  assign out_kind     = out_kind_r;

  assign len_inc     = (len_r < LINE_LEN_MAX) ? len_r + 4'd1 : len_r;
  assign chunk_dec   = chunk_r - COUNT_BITS'(1);
  assign trailer_dec = (trailer_r != 2'd0) ? trailer_r - 2'd1 : 2'd0;

  // size line text: digits, leading spaces, extension
  always_comb begin
    tx_first   = first_r || (len_r == 4'd0 && pop_item.is_zero);
    tx_stopped = stopped_r;
    tx_seen    = seen_r;
    tx_chunk   = chunk_r;
    if (!stopped_r && !(pop_item.is_sp && !seen_r)) begin
      if (!pop_item.hex_ok) begin
        tx_stopped = 1'b1;
      end else begin
        tx_seen = 1'b1;
        if (chunk_r[COUNT_BITS-1 -: 4] != 4'd0) begin
          tx_chunk = '1;
        end else begin
          tx_chunk = {chunk_r[COUNT_BITS-5:0], pop_item.hex_val};
        end
      end
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    chunk_nxt    = chunk_r;
    len_nxt      = len_r;
    first_nxt    = first_r;
    stopped_nxt  = stopped_r;
    seen_nxt     = seen_r;
    trailer_nxt  = trailer_r;
    out_load     = 1'b0;
    out_byte_nxt = 8'd0;
    out_kind_nxt = KIND_PAYLOAD;
    if (take) begin
      case (phase_r)
        PH_LINE, PH_LINE_CR: begin
          if (phase_r == PH_LINE || !pop_item.is_lf) begin
            chunk_nxt   = tx_chunk;
            len_nxt     = len_inc;
            first_nxt   = tx_first;
            stopped_nxt = tx_stopped;
            seen_nxt    = tx_seen;
            if (pop_item.is_cr) begin
              phase_nxt = PH_LINE_CR;
            end else begin
              phase_nxt = PH_LINE;
            end
          end else begin
            len_nxt = len_inc;
            if (first_r && chunk_r == '0) begin
              phase_nxt    = PH_DONE;
              out_load     = 1'b1;
              out_kind_nxt = KIND_END;
            end else if (len_inc > max_len_r) begin
              phase_nxt    = PH_STOPPED;
              out_load     = 1'b1;
              out_kind_nxt = KIND_ERROR;
            end else begin
              trailer_nxt = TRAILER_LEN;
              phase_nxt   = (chunk_r != '0) ? PH_PAYLOAD : PH_TRAILER;
            end
          end
        end
        PH_PAYLOAD: begin
          chunk_nxt    = chunk_dec;
          out_load     = 1'b1;
          out_byte_nxt = pop_item.data;
          out_kind_nxt = KIND_PAYLOAD;
          if (chunk_dec == '0) begin
            trailer_nxt = TRAILER_LEN;
            phase_nxt   = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          trailer_nxt = trailer_dec;
          if (trailer_dec == 2'd0) begin
            chunk_nxt   = '0;
            len_nxt     = 4'd0;
            first_nxt   = 1'b0;
            stopped_nxt = 1'b0;
            seen_nxt    = 1'b0;
            phase_nxt   = PH_LINE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= 4'd6;
      phase_r     <= PH_LINE;
      chunk_r     <= '0;
      len_r       <= 4'd0;
      first_r     <= 1'b0;
      stopped_r   <= 1'b0;
      seen_r      <= 1'b0;
      trailer_r   <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_max_line_len;
      end
      phase_r     <= phase_nxt;
      chunk_r     <= chunk_nxt;
      len_r       <= len_nxt;
      first_r     <= first_nxt;
      stopped_r   <= stopped_nxt;
      seen_r      <= seen_nxt;
      trailer_r   <= trailer_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= out_byte_nxt;
      out_kind_r <= out_kind_nxt;
    end
  end

  `HCD_ASSERT_NOW(a_payload_phase, out_load && out_kind_nxt == KIND_PAYLOAD, phase_r == PH_PAYLOAD)
  `HCD_ASSERT_NEXT(a_done_sticky, phase_r == PH_DONE, phase_r == PH_DONE)
  `HCD_ASSERT_NOW(a_zero_byte, out_valid_r && out_kind_r != KIND_PAYLOAD, out_byte_r == 8'd0)

endmodule
